// ===== rtl/holt_winters_anomaly_scorer_core_assert.svh =====
// Assertion macros for the scorer RTL
`ifndef HOLT_WINTERS_ANOMALY_SCORER_CORE_ASSERT_SVH
`define HOLT_WINTERS_ANOMALY_SCORER_CORE_ASSERT_SVH

// Checked only out of reset; expects clk and rst_n in scope
`define HWAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define HWAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hwas_pkg.sv =====
// Shared constants and saturation helpers of the Holt-Winters scorer
package hwas_pkg;

    localparam int SEASON_LEN = 64;
    localparam int IDX_W      = (SEASON_LEN > 1) ? $clog2(SEASON_LEN) : 1;

    localparam int WEIGHT_W = 17;
    localparam int FACTOR_W = 20;
    localparam int Q49_W    = 49;
    localparam int XMUL_W   = 52;

    localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX = {FACTOR_W{1'b1}};
    localparam logic [Q49_W-1:0]    Q49_MAX    = {1'b0, {(Q49_W-1){1'b1}}};
    localparam logic [Q49_W-1:0]    Q49_MIN    = {1'b1, {(Q49_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEASON_WEIGHT = 2'd2;

    // Operation codes of an input beat
    localparam logic FUNC_INIT  = 1'b0;
    localparam logic FUNC_SCORE = 1'b1;

    // Saturate a 53-bit signed sum into Q32.16
    function automatic logic signed [Q49_W-1:0] sat49(input logic signed [52:0] x);
        logic signed [Q49_W-1:0] r;
        if ((x[52:48] == 5'b00000) || (x[52:48] == 5'b11111))
            r = x[48:0];
        else if (x[52])
            r = Q49_MIN;
        else
            r = Q49_MAX;
        return r;
    endfunction

    // Weights above one read as one
    function automatic logic [WEIGHT_W-1:0] clamp_w(input logic [WEIGHT_W-1:0] w);
        return (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

endpackage

// ===== rtl/hwas_if.sv =====
// Valid/ready channels carrying input beats and scores
interface hwas_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] value;
    logic [31:0] threshold;

    modport source (output valid, func, value, threshold, input ready);
    modport sink   (input valid, func, value, threshold, output ready);
endinterface

interface hwas_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] residual;
    logic        anomaly;

    modport source (output valid, residual, anomaly, input ready);
    modport sink   (input valid, residual, anomaly, output ready);
endinterface

// ===== rtl/hwas_div.sv =====
// Bit-serial restoring divider, 64-bit dividend by 49-bit divisor
module hwas_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [48:0] divisor,
    output logic        busy,
    output logic [63:0] quot
);

    logic [48:0] rem_reg,  rem_next;
    logic [63:0] quot_reg, quot_next;
    logic [48:0] dsr_reg,  dsr_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic [49:0] trial;

    // one quotient bit a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quot_reg[63]};
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = 49'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[48:0];
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/hwas_wmul.sv =====
// Two-stage weight multiply: w * x / 2^16, magnitude truncated
module hwas_wmul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [hwas_pkg::WEIGHT_W-1:0]        w,
    input  logic signed [hwas_pkg::XMUL_W-1:0]   x,
    output logic                                 done,
    output logic signed [hwas_pkg::XMUL_W-1:0]   r
);

    logic [50:0] mag;
    logic [51:0] hi_reg;
    logic [hwas_pkg::WEIGHT_W-1:0] w_reg;
    logic [15:0] mlo_reg;
    logic        neg_reg;
    logic        s1_reg, done_reg;
    logic [32:0] lo;
    logic [51:0] sum;
    logic signed [hwas_pkg::XMUL_W-1:0] r_reg;

    assign mag = x[51] ? 51'(-x) : x[50:0];

    // stage one: upper partial product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg  <= w * mag[50:16];
            w_reg   <= w;
            mlo_reg <= mag[15:0];
            neg_reg <= x[51];
        end
    end

    // stage two: lower partial product, sum and sign
    assign lo  = w_reg * mlo_reg;
    assign sum = hi_reg + {35'd0, lo[32:16]};

    always_ff @(posedge clk)
    begin
        if (s1_reg)
            r_reg <= neg_reg ? -$signed(sum) : $signed(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            done_reg <= s1_reg;
        end
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

// ===== rtl/hwas_fmem.sv =====
// Seasonal factor store: synchronous RAM plus per-slot valid flops
module hwas_fmem (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clr,
    input  logic                             rd_en,
    input  logic [hwas_pkg::IDX_W-1:0]       rd_addr,
    input  logic                             we,
    input  logic [hwas_pkg::IDX_W-1:0]       wr_addr,
    input  logic [hwas_pkg::FACTOR_W-1:0]    wr_data,
    output logic [hwas_pkg::FACTOR_W-1:0]    rd_data,
    output logic                             rd_valid
);

    logic [hwas_pkg::FACTOR_W-1:0] mem [hwas_pkg::SEASON_LEN];
    logic [hwas_pkg::SEASON_LEN-1:0] valid_reg;
    logic [hwas_pkg::FACTOR_W-1:0] rd_data_reg;
    logic rd_valid_reg;

    // RAM port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // valid bits, cleared by reset or init
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
                valid_reg <= '0;
            else if (we)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== rtl/holt_winters_anomaly_scorer_core.sv =====
// Top level of the Holt-Winters anomaly scorer: sequencer, state and datapath
//
//  channel | dir | beat fields
//  --------+-----+---------------------------
//  item    | in  | func, value, threshold
//  score   | out | residual, anomaly
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// An init beat goes from IDLE straight to DONE; a sample beat passes through the sum,
// forecast, divide, multiply, level and write-back states, using two 64-step passes
// through the shared bit-serial divider (the second only for a positive new level) and
// six weight multiplies. One beat is in work at a time; the next is taken while a
// score waits. Reset restores the weights and clears level, trend, index and valid bits.
// A stalled score holds the sequencer in its final state.
`include "holt_winters_anomaly_scorer_core_assert.svh"

module holt_winters_anomaly_scorer_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    hwas_in_if.sink                               item,
    hwas_out_if.source                            score,
    input  logic                                  cfg_we,
    input  logic [hwas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hwas_pkg::WEIGHT_W-1:0]         cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_SUM  = 12'b000000000010,
        ST_FC1  = 12'b000000000100,
        ST_FC2  = 12'b000000001000,
        ST_FC3  = 12'b000000010000,
        ST_WD1  = 12'b000000100000,
        ST_MGO  = 12'b000001000000,
        ST_MWT  = 12'b000010000000,
        ST_LVL  = 12'b000100000000,
        ST_WD2  = 12'b001000000000,
        ST_WB   = 12'b010000000000,
        ST_DONE = 12'b100000000000
    } state_t;

    localparam logic [2:0] OP_A_Q1    = 3'd0;
    localparam logic [2:0] OP_NA_SUM  = 3'd1;
    localparam logic [2:0] OP_B_DL    = 3'd2;
    localparam logic [2:0] OP_NB_TR   = 3'd3;
    localparam logic [2:0] OP_G_Q2    = 3'd4;
    localparam logic [2:0] OP_NG_S    = 3'd5;

    localparam logic [hwas_pkg::IDX_W-1:0] IDX_LAST = hwas_pkg::IDX_W'(hwas_pkg::SEASON_LEN - 1);

    state_t state_reg, state_next;

    logic [hwas_pkg::WEIGHT_W-1:0] alpha_reg, beta_reg, gamma_reg;
    logic signed [48:0] level_reg, trend_reg, sum_reg, q1_reg, nlevel_reg, ntrend_reg;
    logic [hwas_pkg::IDX_W-1:0] idx_reg;
    logic [31:0] v_reg, thr_reg;
    logic [hwas_pkg::FACTOR_W-1:0] s_reg, q2_reg, nf_reg;
    logic [44:0] hi_reg;
    logic [52:0] fm_reg;
    logic [2:0]  op_reg;
    logic signed [51:0] acc_reg;
    logic [31:0] res_pend_reg;
    logic        anom_pend_reg;
    logic        out_valid_reg;
    logic [31:0] out_res_reg;
    logic        out_anom_reg;

    logic accept, init_go;
    logic mem_rd, mem_we, mem_clr, mem_vld;
    logic [hwas_pkg::FACTOR_W-1:0] mem_rdata, s_cur;
    logic div_start, div_busy;
    logic [48:0] div_divisor;
    logic [63:0] div_quot;
    logic mul_start, mul_done;
    logic [hwas_pkg::WEIGHT_W-1:0] mul_w;
    logic signed [51:0] mul_x, mul_r;
    logic signed [52:0] pair_sum;
    logic signed [48:0] sum_cur;
    logic [48:0] fc_mag;
    logic [43:0] fc_lo;
    logic [47:0] vq;
    logic [53:0] dm;
    logic load_out;

    assign accept  = item.valid && item.ready;
    assign init_go = accept && (item.func == hwas_pkg::FUNC_INIT);
    assign item.ready = (state_reg == ST_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 17'd32768;
            beta_reg  <= 17'd6554;
            gamma_reg <= 17'd6554;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hwas_pkg::REG_LEVEL_WEIGHT:  alpha_reg <= cfg_data;
                hwas_pkg::REG_TREND_WEIGHT:  beta_reg  <= cfg_data;
                hwas_pkg::REG_SEASON_WEIGHT: gamma_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // factor store
    assign mem_rd  = accept && (item.func == hwas_pkg::FUNC_SCORE);
    assign mem_clr = init_go;
    assign mem_we  = (state_reg == ST_WB);

    hwas_fmem u_fmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (mem_clr),
        .rd_en    (mem_rd),
        .rd_addr  (idx_reg),
        .we       (mem_we),
        .wr_addr  (idx_reg),
        .wr_data  (nf_reg),
        .rd_data  (mem_rdata),
        .rd_valid (mem_vld)
    );

    // shared divider: v<<32 / s, then v<<32 / new level
    assign div_start   = (state_reg == ST_SUM) ||
                         ((state_reg == ST_LVL) && !nlevel_reg[48] && (nlevel_reg != '0));
    assign div_divisor = (state_reg == ST_SUM) ? {29'd0, s_cur} : nlevel_reg;

    hwas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({v_reg, 32'd0}),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    // shared weight multiplier, operands chosen by step
    assign mul_start = (state_reg == ST_MGO);

    always_comb
    begin
        mul_w = hwas_pkg::clamp_w(alpha_reg);
        mul_x = 52'(q1_reg);
        case (op_reg)
            OP_A_Q1:
            begin
                mul_w = hwas_pkg::clamp_w(alpha_reg);
                mul_x = 52'(q1_reg);
            end
            OP_NA_SUM:
            begin
                mul_w = 17'(hwas_pkg::ONE_Q16 - hwas_pkg::clamp_w(alpha_reg));
                mul_x = 52'(sum_reg);
            end
            OP_B_DL:
            begin
                mul_w = hwas_pkg::clamp_w(beta_reg);
                mul_x = 52'(nlevel_reg) - 52'(level_reg);
            end
            OP_NB_TR:
            begin
                mul_w = 17'(hwas_pkg::ONE_Q16 - hwas_pkg::clamp_w(beta_reg));
                mul_x = 52'(trend_reg);
            end
            OP_G_Q2:
            begin
                mul_w = hwas_pkg::clamp_w(gamma_reg);
                mul_x = {32'd0, q2_reg};
            end
            OP_NG_S:
            begin
                mul_w = 17'(hwas_pkg::ONE_Q16 - hwas_pkg::clamp_w(gamma_reg));
                mul_x = {32'd0, s_reg};
            end
            default: ;
        endcase
    end

    hwas_wmul u_wmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .w     (mul_w),
        .x     (mul_x),
        .done  (mul_done),
        .r     (mul_r)
    );

    // datapath terms
    assign s_cur    = mem_vld ? mem_rdata : hwas_pkg::FACTOR_W'(hwas_pkg::ONE_Q16);
    assign sum_cur  = hwas_pkg::sat49(53'(level_reg) + 53'(trend_reg));
    assign fc_mag   = sum_reg[48] ? 49'(-sum_reg) : sum_reg;
    assign fc_lo    = fc_mag[23:0] * s_reg;
    assign vq       = {v_reg, 16'd0};
    assign pair_sum = 53'(acc_reg) + 53'(mul_r);

    always_comb
    begin
        if (sum_reg[48])
            dm = 54'(vq) + 54'(fm_reg);
        else if (53'(vq) >= fm_reg)
            dm = 54'(53'(vq) - fm_reg);
        else
            dm = 54'(fm_reg - 53'(vq));
    end

    assign load_out = !out_valid_reg || score.ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = init_go ? ST_DONE : ST_SUM;
            ST_SUM:  state_next = ST_FC1;
            ST_FC1:  state_next = ST_FC2;
            ST_FC2:  state_next = ST_FC3;
            ST_FC3:  state_next = ST_WD1;
            ST_WD1:  if (!div_busy) state_next = ST_MGO;
            ST_MGO:  state_next = ST_MWT;
            ST_MWT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_NA_SUM: state_next = ST_LVL;
                        OP_NB_TR:  state_next = ST_WD2;
                        OP_NG_S:   state_next = ST_WB;
                        default:   state_next = ST_MGO;
                    endcase
                end
            end
            ST_LVL:  state_next = ST_MGO;
            ST_WD2:  if (!div_busy) state_next = ST_MGO;
            ST_WB:   state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            trend_reg     <= '0;
            idx_reg       <= '0;
            op_reg        <= OP_A_Q1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (init_go)
            begin
                level_reg <= {1'b0, item.value, 16'd0};
                trend_reg <= '0;
                idx_reg   <= '0;
            end
            if (state_reg == ST_WB)
            begin
                level_reg <= nlevel_reg;
                trend_reg <= ntrend_reg;
                idx_reg   <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            end
            if (state_reg == ST_WD1)
                op_reg <= OP_A_Q1;
            else if ((state_reg == ST_MWT) && mul_done)
                op_reg <= op_reg + 3'd1;
            if ((state_reg == ST_DONE) && load_out)
                out_valid_reg <= 1'b1;
            else if (score.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg         <= item.value;
            thr_reg       <= item.threshold;
            res_pend_reg  <= '0;
            anom_pend_reg <= 1'b0;
        end
        if (state_reg == ST_SUM)
        begin
            s_reg   <= s_cur;
            sum_reg <= sum_cur;
        end
        if (state_reg == ST_FC1)
            hi_reg <= fc_mag[48:24] * s_reg;
        if (state_reg == ST_FC2)
            fm_reg <= {hi_reg, 8'd0} + {25'd0, fc_lo[43:16]};
        if (state_reg == ST_FC3)
        begin
            res_pend_reg  <= (dm[53:48] != '0) ? 32'hFFFF_FFFF : dm[47:16];
            anom_pend_reg <= (dm > {6'd0, thr_reg, 16'd0});
        end
        if ((state_reg == ST_WD1) && !div_busy)
            q1_reg <= ((s_reg == '0) || (div_quot[63:48] != '0)) ?
                      hwas_pkg::Q49_MAX : {1'b0, div_quot[47:0]};
        if ((state_reg == ST_WD2) && !div_busy)
            q2_reg <= (nlevel_reg[48] || (nlevel_reg == '0) || (div_quot[63:20] != '0)) ?
                      hwas_pkg::FACTOR_MAX : div_quot[19:0];
        if ((state_reg == ST_MWT) && mul_done)
        begin
            acc_reg <= mul_r;
            case (op_reg)
                OP_NA_SUM: nlevel_reg <= hwas_pkg::sat49(pair_sum);
                OP_NB_TR:  ntrend_reg <= hwas_pkg::sat49(pair_sum);
                OP_NG_S:
                begin
                    if (pair_sum[52])
                        nf_reg <= '0;
                    else if (pair_sum > 53'(hwas_pkg::FACTOR_MAX))
                        nf_reg <= hwas_pkg::FACTOR_MAX;
                    else
                        nf_reg <= pair_sum[hwas_pkg::FACTOR_W-1:0];
                end
                default: ;
            endcase
        end
        if ((state_reg == ST_DONE) && load_out)
        begin
            out_res_reg  <= res_pend_reg;
            out_anom_reg <= anom_pend_reg;
        end
    end

    assign score.valid    = out_valid_reg;
    assign score.residual = out_res_reg;
    assign score.anomaly  = out_anom_reg;

    `HWAS_ASSERT(a_score_goes_to_sum, (accept && item.func == hwas_pkg::FUNC_SCORE) |=> (state_reg == ST_SUM), "sample beat did not start the sum step")
    `HWAS_ASSERT(a_div_not_busy, div_start |-> !div_busy, "divider restarted while busy")
    `HWAS_ASSERT(a_idx_advance, (state_reg == ST_WB) |=> (idx_reg == (($past(idx_reg) == IDX_LAST) ? '0 : $past(idx_reg) + 1'b1)), "season index did not advance after write-back")
    `HWAS_ASSERT_ALWAYS(a_mem_excl, !(mem_we && (mem_rd || mem_clr)), "factor store written while read or cleared")

endmodule

// ===== bench/holt_winters_anomaly_scorer_core_tb.sv =====
// Self-checking bench for the Holt-Winters anomaly scorer core
module holt_winters_anomaly_scorer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          SETTLE_CYC  = 200;
    localparam longint      LEVEL_MAX   = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint      LEVEL_MIN   = -LEVEL_MAX - 1;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    typedef struct {
        logic        func;
        logic [31:0] value;
        logic [31:0] threshold;
    } flow_beat_t;

    typedef struct {
        logic [31:0] residual;
        logic        anomaly;
    } score_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [hwas_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hwas_pkg::WEIGHT_W-1:0]  cfg_data;

    hwas_in_if  item_ch ();
    hwas_out_if score_ch ();

    holt_winters_anomaly_scorer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .score     (score_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the scorer state and weights
    logic [hwas_pkg::WEIGHT_W-1:0]   alpha_sh, beta_sh, gamma_sh;
    longint                          level_sh, trend_sh;
    logic [19:0]                     factor_sh [hwas_pkg::SEASON_LEN];
    logic [hwas_pkg::SEASON_LEN-1:0] factor_ok;
    int                              slot_sh;

    flow_beat_t  pending_beats [$];
    score_beat_t scores_due [$];

    int  errors, cycles, gap_cnt, stall_cnt;
    int  n_init, n_sample, n_anom, n_satur;
    bit  hold_off, no_idle;

    always #4 clk = ~clk;

    function automatic longint unsigned mag(input longint x);
        return (x < 0) ? (64'd0 - longint'(x)) : longint'(x);
    endfunction

    function automatic longint clip_q49(input longint x);
        if (x > LEVEL_MAX) return LEVEL_MAX;
        if (x < LEVEL_MIN) return LEVEL_MIN;
        return x;
    endfunction

    // w in Q1.16 times x, each part truncated toward zero
    function automatic longint weigh(input longint unsigned w, input longint x);
        longint unsigned m, r;
        m = mag(x);
        r = w * (m >> 16) + ((w * (m & 64'hFFFF)) >> 16);
        return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned eff_weight(input logic [hwas_pkg::WEIGHT_W-1:0] w);
        return (w > hwas_pkg::ONE_Q16) ? 64'd65536 : 64'(w);
    endfunction

    // Forecast, score and smoothing update for one sample beat; an init beat resets the shadow
    function automatic score_beat_t score_flow(input flow_beat_t b);
        score_beat_t     r;
        longint unsigned s, a, be, g, m, fm, dm, ri, q;
        longint          sum, fc, vq, q1, q2, nl, nt, nf;
        if (b.func == hwas_pkg::FUNC_INIT) begin
            level_sh  = longint'(64'(b.value) << 16);
            trend_sh  = 0;
            slot_sh   = 0;
            factor_ok = '0;
            r.residual = '0;
            r.anomaly  = 1'b0;
            return r;
        end
        s  = factor_ok[slot_sh] ? 64'(factor_sh[slot_sh]) : 64'd65536;
        a  = eff_weight(alpha_sh);
        be = eff_weight(beta_sh);
        g  = eff_weight(gamma_sh);

        sum = clip_q49(level_sh + trend_sh);
        m   = mag(sum);
        fm  = (((m >> 24) * s) << 8) + (((m & 64'hFF_FFFF) * s) >> 16);
        fc  = (sum < 0) ? -longint'(fm) : longint'(fm);
        vq  = longint'(64'(b.value) << 16);
        dm  = mag(vq - fc);
        ri  = dm >> 16;
        r.residual = (ri > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ri[31:0];
        r.anomaly  = dm > (64'(b.threshold) << 16);

        // level
        if (s == 0)
            q1 = LEVEL_MAX;
        else
        begin
            q  = (64'(b.value) << 32) / s;
            q1 = (q > 64'(LEVEL_MAX)) ? LEVEL_MAX : longint'(q);
        end
        nl = clip_q49(weigh(a, q1) + weigh(64'd65536 - a, sum));
        nt = clip_q49(weigh(be, nl - level_sh) + weigh(64'd65536 - be, trend_sh));

        // seasonal factor
        if (nl <= 0)
            q2 = 64'hF_FFFF;
        else
        begin
            q  = (64'(b.value) << 32) / longint'(nl);
            q2 = (q > 64'hF_FFFF) ? 64'hF_FFFF : longint'(q);
        end
        nf = weigh(g, q2) + weigh(64'd65536 - g, longint'(s));
        if (nf < 0) nf = 0;
        if (nf > 64'hF_FFFF) nf = 64'hF_FFFF;

        level_sh           = nl;
        trend_sh           = nt;
        factor_sh[slot_sh] = nf[19:0];
        factor_ok[slot_sh] = 1'b1;
        slot_sh            = (slot_sh + 1 >= hwas_pkg::SEASON_LEN) ? 0 : slot_sh + 1;
        return r;
    endfunction

    // Driver: presents queued beats, predicts each accepted one
    always @(posedge clk)
    begin
        flow_beat_t nxt;
        int         g;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                nxt.func      = item_ch.func;
                nxt.value     = item_ch.value;
                nxt.threshold = item_ch.threshold;
                scores_due.push_back(score_flow(nxt));
                g = no_idle ? 0 : $urandom_range(0, 6);
                if (g == 0 && pending_beats.size() > 0 && !hold_off)
                begin
                    nxt = pending_beats.pop_front();
                    item_ch.func      <= nxt.func;
                    item_ch.value     <= nxt.value;
                    item_ch.threshold <= nxt.threshold;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                    gap_cnt       <= g;
                end
            end
            else if (!item_ch.valid)
            begin
                if (gap_cnt > 0)
                    gap_cnt <= gap_cnt - 1;
                else if (pending_beats.size() > 0 && !hold_off)
                begin
                    nxt = pending_beats.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.func      <= nxt.func;
                    item_ch.value     <= nxt.value;
                    item_ch.threshold <= nxt.threshold;
                end
            end
        end
    end

    // Monitor: random backpressure, checks each score beat
    always @(posedge clk)
    begin
        score_beat_t e;
        int          st;
        if (rst_n)
        begin
            if (score_ch.valid && score_ch.ready)
            begin
                if (scores_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: score beat with nothing expected: residual %0d anomaly %0b",
                             $realtime, score_ch.residual, score_ch.anomaly);
                end
                else
                begin
                    e = scores_due.pop_front();
                    if (score_ch.residual !== e.residual)
                    begin
                        errors++;
                        $display("%0t: residual expected %0d actual %0d",
                                 $realtime, e.residual, score_ch.residual);
                    end
                    if (score_ch.anomaly !== e.anomaly)
                    begin
                        errors++;
                        $display("%0t: anomaly expected %0b actual %0b",
                                 $realtime, e.anomaly, score_ch.anomaly);
                    end
                    if (e.anomaly) n_anom++;
                    if (e.residual == 32'hFFFF_FFFF) n_satur++;
                end
                st = no_idle ? 0 : $urandom_range(0, 6);
                if (st > 0)
                begin
                    score_ch.ready <= 1'b0;
                    stall_cnt      <= st;
                end
            end
            else if (!score_ch.ready)
            begin
                if (stall_cnt > 1)
                    stall_cnt <= stall_cnt - 1;
                else
                    score_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("holt_winters_anomaly_scorer_core_tb: errors");
            $finish;
        end
    end

    task automatic queue_beat(input logic f, input logic [31:0] v, input logic [31:0] thr);
        flow_beat_t b;
        b.func      = f;
        b.value     = v;
        b.threshold = thr;
        pending_beats.push_back(b);
        if (f == hwas_pkg::FUNC_INIT) n_init++;
        else n_sample++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [hwas_pkg::WEIGHT_W-1:0] d);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            hwas_pkg::REG_LEVEL_WEIGHT:  alpha_sh = d;
            hwas_pkg::REG_TREND_WEIGHT:  beta_sh  = d;
            hwas_pkg::REG_SEASON_WEIGHT: gamma_sh = d;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for the block to drain, then let its longest latency pass
    task automatic drain();
        do @(posedge clk);
        while (pending_beats.size() != 0 || item_ch.valid || scores_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] base);
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return base + $urandom_range(0, base / 4 + 8) - (base / 8 + 4);
        if (k < 70) return 32'd0;
        if (k < 75) return 32'hFFFF_FFFF;
        if (k < 90) return $urandom;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [31:0] pick_threshold(input logic [31:0] base);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 32'd0;
        if (k == 1) return 32'hFFFF_FFFF;
        if (k < 5)  return $urandom;
        return $urandom_range(0, base / 4 + 16);
    endfunction

    // One season-tracking run: init, then samples mostly around a base value with rare re-inits
    task automatic queue_run(output int n);
        logic [31:0] base;
        int          len, k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1:    base = $urandom_range(0, 1000);
            2:       base = $urandom;
            3:       base = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: base = $urandom_range(1000, 50000000);
        endcase
        queue_beat(hwas_pkg::FUNC_INIT, base, $urandom);
        n = 1;
        if ($urandom_range(0, 9) == 0)
        begin
            // long zero run drives factors toward zero, then back to normal
            len = $urandom_range(70, 140);
            for (int j = 0; j < len; j++)
                queue_beat(hwas_pkg::FUNC_SCORE, (j < 66) ? 32'd0 : base,
                           pick_threshold(base));
            n += len;
        end
        else
        begin
            len = $urandom_range(1, 100);
            repeat (len)
            begin
                if ($urandom_range(0, 49) == 0)
                    queue_beat(hwas_pkg::FUNC_INIT, $urandom, $urandom);
                else
                    queue_beat(hwas_pkg::FUNC_SCORE, pick_value(base), pick_threshold(base));
                n++;
            end
        end
    endtask

    initial
    begin
        logic [hwas_pkg::WEIGHT_W-1:0] w_a [6];
        logic [hwas_pkg::WEIGHT_W-1:0] w_b [6];
        logic [hwas_pkg::WEIGHT_W-1:0] w_g [6];
        int n, queued;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = hwas_pkg::REG_LEVEL_WEIGHT;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.func = hwas_pkg::FUNC_INIT;
        item_ch.value = '0;
        item_ch.threshold = '0;
        score_ch.ready = 1'b1;
        alpha_sh = 17'd32768;
        beta_sh  = 17'd6554;
        gamma_sh = 17'd6554;
        level_sh = 0;
        trend_sh = 0;
        slot_sh = 0;
        factor_ok = '0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        errors = 0;
        cycles = 0;
        gap_cnt = 0;
        stall_cnt = 0;

        w_a = '{17'd32768, 17'd0,     17'd65536, 17'h1FFFF, 17'd0, 17'd0};
        w_b = '{17'd6554,  17'd0,     17'd65536, 17'd70000, 17'd0, 17'd0};
        w_g = '{17'd6554,  17'd0,     17'd65536, 17'd65537, 17'd0, 17'd0};
        for (int i = 4; i < 6; i++)
        begin
            w_a[i] = 17'($urandom_range(0, 65536));
            w_b[i] = 17'($urandom_range(0, 65536));
            w_g[i] = 17'($urandom_range(0, 65536));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, samples before any init, saturation
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd0,        32'd0);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'hFFFF_FFFF, 32'd0);
        queue_beat(hwas_pkg::FUNC_INIT,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd0,        32'hFFFF_FFFF);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd0,        32'd0);
        queue_beat(hwas_pkg::FUNC_INIT,  32'd0,        32'd0);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd1,        32'd0);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd1,        32'd1);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_beat(hwas_pkg::FUNC_INIT,  32'd1000,     32'd0);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd1000,     32'd0);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd1010,     32'd9);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'd0,        32'd500);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'hAAAA_5555, 32'h5555_AAAA);
        queue_beat(hwas_pkg::FUNC_SCORE, 32'h5555_AAAA, 32'hAAAA_5555);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                write_reg(hwas_pkg::REG_LEVEL_WEIGHT,  w_a[p]);
                write_reg(hwas_pkg::REG_TREND_WEIGHT,  w_b[p]);
                write_reg(hwas_pkg::REG_SEASON_WEIGHT, w_g[p]);
                write_reg(REG_UNUSED, 17'($urandom));
            end
            no_idle = (p == 3);
            queued = 0;
            while (queued < 160)
            begin
                queue_run(n);
                queued += n;
                // hold the sender once until every score is back
                if (p == 1 && queued >= 90 && queued - n < 90)
                begin
                    do @(posedge clk);
                    while (pending_beats.size() != 0);
                    hold_off <= 1'b1;
                    do @(posedge clk);
                    while (item_ch.valid || scores_due.size() != 0);
                    hold_off <= 1'b0;
                end
            end
            drain();
        end

        $display("Covered %0d init and %0d sample beats over 6 weight settings,",
                 n_init, n_sample);
        $display("%0d flagged anomalies and %0d saturated residuals.", n_anom, n_satur);
        if (errors == 0)
            $display("holt_winters_anomaly_scorer_core_tb: clean");
        else
            $display("holt_winters_anomaly_scorer_core_tb: errors");
        $finish;
    end

endmodule
